// ===== design/isqr_pkg.sv =====
// Shared sizing functions for the rounded integer square root pipeline.
// No dependencies.
package isqr_pkg;

  // One pipeline step per bit pair of the radicand.
  function automatic int stage_count(input int width);
    return (width + 1) / 2;
  endfunction

  // Floor root bits plus one bit for the round-up carry.
  function automatic int root_width(input int width);
    return (width + 1) / 2 + 1;
  endfunction

  // Bit position of the highest power of four within the radicand width.
  function automatic int top_pair_bit(input int width);
    return (width - 1) & ~1;
  endfunction

endpackage

// ===== design/isqr_stage.sv =====
// One restoring square root step: trial subtract of one bit pair, one root bit.
// Depends on isqr_pkg.
module isqr_stage
  import isqr_pkg::*;
#(
  parameter int Width  = 32,
  parameter int BitPos = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [Width-1:0] rem_i,
  input  logic [Width:0]   acc_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [Width-1:0] rem_o,
  output logic [Width:0]   acc_o
);

  localparam int AccWidth = Width + 1;
  localparam logic [AccWidth-1:0] BitVal = AccWidth'(1) << BitPos;

  logic                valid_q;
  logic [Width-1:0]    rem_d, rem_q;
  logic [AccWidth-1:0] acc_d, acc_q;
  logic [AccWidth-1:0] trial;
  logic [AccWidth-1:0] acc_sel;
  logic                take;

  assign ready_o = !valid_q || ready_i;
  assign trial   = acc_i + BitVal;
  assign take    = {1'b0, rem_i} >= trial;

  always_comb begin
    if (take) begin
      rem_d   = rem_i - trial[Width-1:0];
      acc_sel = trial + BitVal;
    end else begin
      rem_d   = rem_i;
      acc_sel = acc_i;
    end
    acc_d = acc_sel >> 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rem_q <= rem_d;
      acc_q <= acc_d;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign acc_o   = acc_q;

endmodule

// ===== design/isqr_round.sv =====
// Final stage: round the floor root up when the remainder exceeds it.
// Depends on isqr_pkg; holds the output register.
module isqr_round
  import isqr_pkg::*;
#(
  parameter int Width = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [Width-1:0]              rem_i,
  input  logic [Width:0]                acc_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [root_width(Width)-1:0]  root_o
);

  localparam int RootWidth = root_width(Width);

  logic                 valid_q;
  logic [RootWidth-1:0] root_d, root_q;
  logic                 round_up;

  assign ready_o  = !valid_q || ready_i;
  assign round_up = {1'b0, rem_i} > acc_i;
  assign root_d   = acc_i[RootWidth-1:0] + RootWidth'(round_up);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      root_q <= root_d;
    end
  end

  assign valid_o = valid_q;
  assign root_o  = root_q;

endmodule

// ===== design/integer_sqrt_rounded_core.sv =====
// Rounded integer square root: one beat in, one beat out, root rounded to nearest.
// Depends on isqr_pkg, isqr_stage and isqr_round.
//
// Accepts one radicand per cycle while the output is taken and returns one root
// per radicand, in order. The work runs through a pipeline of (INPUT_WIDTH+1)/2
// restoring steps, one root bit per register stage, followed by a rounding stage
// that is also the output register; throughput is one beat per cycle while the
// output is taken. Each stage has its own valid bit; a stalled output holds its
// beat and the stages behind it fill their bubbles before the input backs up.
module integer_sqrt_rounded_core
  import isqr_pkg::*;
#(
  parameter int INPUT_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [INPUT_WIDTH-1:0]              radicand_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [root_width(INPUT_WIDTH)-1:0]  root_o
);

  localparam int Stages = stage_count(INPUT_WIDTH);
  localparam int TopBit = top_pair_bit(INPUT_WIDTH);

  logic                   valid [Stages+1];
  logic                   ready [Stages+1];
  logic [INPUT_WIDTH-1:0] rem   [Stages+1];
  logic [INPUT_WIDTH:0]   acc   [Stages+1];

  assign valid[0]   = in_valid_i;
  assign in_ready_o = ready[0];
  assign rem[0]     = radicand_i;
  assign acc[0]     = '0;

  for (genvar k = 0; k < Stages; k++) begin : g_step
    isqr_stage #(
      .Width  (INPUT_WIDTH),
      .BitPos (TopBit - 2 * k)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[k]),
      .ready_o (ready[k]),
      .rem_i   (rem[k]),
      .acc_i   (acc[k]),
      .valid_o (valid[k+1]),
      .ready_i (ready[k+1]),
      .rem_o   (rem[k+1]),
      .acc_o   (acc[k+1])
    );
  end

  isqr_round #(
    .Width (INPUT_WIDTH)
  ) u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid[Stages]),
    .ready_o (ready[Stages]),
    .rem_i   (rem[Stages]),
    .acc_i   (acc[Stages]),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .root_o  (root_o)
  );

endmodule

// ===== design/isqr_checker.sv =====
// Port-level checks for integer_sqrt_rounded_core, attached by bind.
// Depends on isqr_pkg.
module isqr_checker
  import isqr_pkg::*;
#(
  parameter int INPUT_WIDTH = 32
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic [INPUT_WIDTH-1:0]              radicand_i,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic [root_width(INPUT_WIDTH)-1:0]  root_o
);

  localparam int RootWidth = root_width(INPUT_WIDTH);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(radicand_i))
    else $error("input beat dropped or changed while waiting");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(root_o))
    else $error("output beat dropped or changed while stalled");

  a_carry_only_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && root_o[RootWidth-1] |-> root_o[RootWidth-2:0] == '0)
    else $error("round-up carry with nonzero low root bits");

  a_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input backed up while output drains");

endmodule

bind integer_sqrt_rounded_core isqr_checker #(
  .INPUT_WIDTH (INPUT_WIDTH)
) u_isqr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .radicand_i  (radicand_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .root_o      (root_o)
);

// ===== sim/tb.sv =====
// Self-checking testbench for integer_sqrt_rounded_core at the default 32-bit width.
// Drives radicands over valid/ready, predicts each rounded root and compares in order.
// Depends on isqr_pkg and the core RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import isqr_pkg::*;

  localparam int RAD_W       = 32;
  localparam int ROOT_W      = root_width(RAD_W);
  localparam int N_RANDOM    = 1900;
  localparam int HOLD_AT     = 400;
  localparam int HOLD_CYCLES = 120;
  localparam int QUIET_TAIL  = 250;
  localparam int DRAIN_WAIT  = 40;
  localparam int LIMIT       = 2000;
  localparam int MAX_REPORTS = 10;

  class root_ledger;
    logic [ROOT_W-1:0] pending_roots[$];
    logic [RAD_W-1:0]  pending_radicands[$];
    int                mismatches;
    int                checked;

    static function logic [ROOT_W-1:0] nearest_root(input logic [RAD_W-1:0] x);
      bit [63:0] rem;
      bit [63:0] acc;
      bit [63:0] weight;
      bit [63:0] trial;
      rem    = 64'(x);
      acc    = '0;
      weight = 64'd1 << top_pair_bit(RAD_W);
      while (weight != 0) begin
        trial = acc + weight;
        if (rem >= trial) begin
          rem = rem - trial;
          acc = trial + weight;
        end
        acc    = acc >> 1;
        weight = weight >> 2;
      end
      if (rem > acc) acc = acc + 1;
      return acc[ROOT_W-1:0];
    endfunction

    function void note_radicand(input logic [RAD_W-1:0] x);
      pending_radicands.push_back(x);
      pending_roots.push_back(nearest_root(x));
    endfunction

    function void check_root(input logic [ROOT_W-1:0] got);
      logic [ROOT_W-1:0] want;
      logic [RAD_W-1:0]  x;
      checked++;
      if (pending_roots.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected root %0d with nothing outstanding", got);
        return;
      end
      want = pending_roots.pop_front();
      x    = pending_radicands.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("root mismatch: radicand 0x%08h expected %0d got %0d", x, want, got);
      end
    endfunction

    function int pending();
      return pending_roots.size();
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [RAD_W-1:0]  radicand_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [ROOT_W-1:0] root_o;

  root_ledger        ledger = new();
  logic [RAD_W-1:0]  radicands[$];
  int                beats_in;
  int                total_beats;
  bit                quiet;
  bit                hold_done;

  integer_sqrt_rounded_core #(
    .INPUT_WIDTH(RAD_W)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .radicand_i (radicand_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .root_o     (root_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) ledger.check_root(root_o);
  end

  task automatic push_radicand(input logic [RAD_W-1:0] x);
    in_valid_i <= 1'b1;
    radicand_i <= x;
    do @(posedge clk_i); while (!in_ready_o);
    ledger.note_radicand(x);
    beats_in++;
    quiet = (beats_in >= total_beats - QUIET_TAIL);
  endtask

  task automatic pause_sender(input int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  function automatic logic [RAD_W-1:0] random_radicand();
    longint unsigned n;
    longint signed   v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6: begin
        n = $urandom_range(0, 65535);
        case ($urandom_range(0, 5))
          0: v = longint'(n * n) - 1;
          1: v = longint'(n * n);
          2: v = longint'(n * n) + 1;
          3: v = longint'(n * n + n);
          4: v = longint'(n * n + n) + 1;
          default: v = longint'(n * n + $urandom_range(0, 2 * 32'(n) + 1));
        endcase
        if (v < 0 || v > 64'hFFFF_FFFF) return $urandom;
        return v[RAD_W-1:0];
      end
      7: return $urandom_range(0, 1023);
      8: return 32'hFFFF_0000 + $urandom_range(0, 65535);
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  initial begin : source
    in_valid_i <= 1'b0;
    radicand_i <= '0;
    radicands = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd6, 32'd7,
                  32'hFFFF_FFFF, 32'hFFFF_0000, 32'hFFFF_0001, 32'hFFFE_0001,
                  32'hFFFE_0000, 32'h8000_0000, 32'h4000_0000, 32'h3FFF_FFFF,
                  32'h5555_5555, 32'hAAAA_AAAA, 32'h0001_0000, 32'h0000_FFFF,
                  32'h7FFF_FFFF, 32'hC000_0000};
    for (int i = 0; i < N_RANDOM; i++) radicands.push_back(random_radicand());
    total_beats = radicands.size();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (radicands[i]) begin
      if (!quiet && !(beats_in >= HOLD_AT && !hold_done) && $urandom_range(0, 5) == 0)
        pause_sender($urandom_range(1, 13));
      push_radicand(radicands[i]);
    end
    in_valid_i <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("Sent %0d radicands (directed edges, near-square and top-of-range sweeps),",
             beats_in);
    $display("checked %0d roots with a %0d-cycle output hold; %0d mismatches.",
             ledger.checked, HOLD_CYCLES, ledger.mismatches);
    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : sink
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!hold_done && beats_in >= HOLD_AT) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
        out_ready_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Timeout: no beat moved for %0d cycles", LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
